// ===== sv/lcss_pkg.sv =====
// Shared types and constants for the LED channel store serializer.
package lcss_pkg;

    localparam int LED_COUNT_DEF = 8;
    localparam int LANES         = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [5:0] BRI_RESET = 6'h3f;
    localparam logic [7:0] CHAN_ON   = 8'hff;
    localparam logic [7:0] CHAN_OFF  = 8'h00;
    localparam logic [6:0] PCT_MAX   = 7'd100;
    // 63/100 scaled by 2^16
    localparam logic [15:0] BRI_SCALE = 16'd41288;
    // 1/3 scaled by 2^7, exact for values below 128
    localparam logic [12:0] DIV3_MUL  = 13'd43;

    typedef enum logic [2:0] {
        MODE_BRIGHT = 3'd0,
        MODE_ON     = 3'd1,
        MODE_OFF    = 3'd2,
        MODE_COLOR  = 3'd3,
        MODE_CHAN   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ERR    = 2'd0,
        KIND_BRIGHT = 2'd1,
        KIND_LED    = 2'd2,
        KIND_CHAN   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t           kind;
        logic [4:0]      row;
        logic [1:0]      lane;
        logic [2:0][7:0] val;
        logic            flush;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WRITE = 2'd1,
        ST_READ  = 2'd2,
        ST_EMIT  = 2'd3
    } state_t;

endpackage

// ===== sv/lcss_front.sv =====
// Front stage: checks and decodes request words into store commands.
module lcss_front #(
    parameter int LED_COUNT = lcss_pkg::LED_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  logic [2:0]    mode,
    input  logic [4:0]    led_index,
    input  logic [7:0]    brightness_percent,
    input  logic [1:0]    color_count,
    input  logic [7:0]    red_value,
    input  logic [7:0]    green_value,
    input  logic [7:0]    blue_value,
    input  logic [6:0]    channel_index,
    input  logic [7:0]    channel_value,
    input  logic          burst_last,
    output logic          push,
    output lcss_pkg::cmd_t push_cmd,
    input  logic          push_ready
);

    localparam int CHAN_TOTAL = lcss_pkg::LANES * LED_COUNT;

    logic           vld_reg;
    logic           vld_next;
    lcss_pkg::cmd_t cmd_reg;
    lcss_pkg::cmd_t dec;
    logic           accept;
    logic           led_bad;
    logic           chan_bad;
    logic [6:0]     pct_sat;
    logic [22:0]    bri_prod;
    logic [5:0]     bri_v;
    logic [12:0]    div_prod;
    logic [5:0]     quo;
    logic [6:0]     rem;

    assign req_stall = vld_reg && !push_ready;
    assign accept    = req_valid && !req_stall;
    assign push      = vld_reg;
    assign push_cmd  = cmd_reg;

    assign led_bad  = {1'b0, led_index} >= 6'(LED_COUNT);
    assign chan_bad = {1'b0, channel_index} >= 8'(CHAN_TOTAL);

    assign pct_sat  = (brightness_percent > {1'b0, lcss_pkg::PCT_MAX}) ?
                      lcss_pkg::PCT_MAX : brightness_percent[6:0];
    assign bri_prod = {16'd0, pct_sat} * {7'd0, lcss_pkg::BRI_SCALE};
    assign bri_v    = bri_prod[21:16];

    assign div_prod = {6'd0, channel_index} * lcss_pkg::DIV3_MUL;
    assign quo      = div_prod[12:7];
    assign rem      = channel_index - ({1'b0, quo} + {quo, 1'b0});

    always_comb
    begin
        dec       = '0;
        dec.kind  = lcss_pkg::KIND_ERR;
        dec.row   = led_index;
        case (mode)
            lcss_pkg::MODE_BRIGHT:
            begin
                dec.kind  = led_bad ? lcss_pkg::KIND_ERR : lcss_pkg::KIND_BRIGHT;
                dec.val   = {3{2'b00, bri_v}};
                dec.flush = 1'b1;
            end
            lcss_pkg::MODE_ON:
            begin
                dec.kind  = led_bad ? lcss_pkg::KIND_ERR : lcss_pkg::KIND_LED;
                dec.val   = {3{lcss_pkg::CHAN_ON}};
                dec.flush = 1'b1;
            end
            lcss_pkg::MODE_OFF:
            begin
                dec.kind  = led_bad ? lcss_pkg::KIND_ERR : lcss_pkg::KIND_LED;
                dec.val   = {3{lcss_pkg::CHAN_OFF}};
                dec.flush = 1'b1;
            end
            lcss_pkg::MODE_COLOR:
            begin
                dec.kind   = led_bad ? lcss_pkg::KIND_ERR : lcss_pkg::KIND_LED;
                dec.val[0] = (color_count >= 2'd1) ? red_value   : lcss_pkg::CHAN_OFF;
                dec.val[1] = (color_count >= 2'd2) ? green_value : lcss_pkg::CHAN_OFF;
                dec.val[2] = (color_count == 2'd3) ? blue_value  : lcss_pkg::CHAN_OFF;
                dec.flush  = 1'b1;
            end
            lcss_pkg::MODE_CHAN:
            begin
                dec.kind  = chan_bad ? lcss_pkg::KIND_ERR : lcss_pkg::KIND_CHAN;
                dec.row   = quo[4:0];
                dec.lane  = rem[1:0];
                dec.val   = {3{channel_value}};
                dec.flush = burst_last;
            end
            default:
            begin
                dec.kind = lcss_pkg::KIND_ERR;
            end
        endcase
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
            vld_next = 1'b1;
        else if (push_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= dec;
    end

endmodule

// ===== sv/lcss_queue.sv =====
// Short command queue between the front and back stages.
module lcss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lcss_pkg::cmd_t push_cmd,
    output logic           push_ready,
    output logic           pop_valid,
    output lcss_pkg::cmd_t pop_cmd,
    input  logic           pop
);

    localparam int PTR_W = (lcss_pkg::QUEUE_DEPTH > 1) ? $clog2(lcss_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lcss_pkg::QUEUE_DEPTH + 1);

    lcss_pkg::cmd_t   mem_reg [lcss_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = cnt_reg != CNT_W'(lcss_pkg::QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lcss_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lcss_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== sv/lcss_back.sv =====
// Back stage: updates the brightness and channel stores and serializes a bank.
module lcss_back #(
    parameter int LED_COUNT = lcss_pkg::LED_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  lcss_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output logic           status,
    output logic           bank,
    output logic [7:0]     word,
    output logic           last
);

    localparam int ROW_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int LANES = lcss_pkg::LANES;

    logic [5:0] bri_mem  [LANES][LED_COUNT];
    logic [7:0] chan_mem [LANES][LED_COUNT];

    logic [LANES-1:0][LED_COUNT-1:0] bri_vld_reg;
    logic [LANES-1:0][LED_COUNT-1:0] chan_vld_reg;
    logic [5:0]                      bri_rd_reg  [LANES];
    logic [7:0]                      chan_rd_reg [LANES];
    logic [LANES-1:0]                bri_vld_rd_reg;
    logic [LANES-1:0]                chan_vld_rd_reg;

    lcss_pkg::state_t state_reg;
    lcss_pkg::state_t state_next;
    lcss_pkg::cmd_t   cmd_reg;
    lcss_pkg::cmd_t   cmd_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [1:0]       lane_reg;
    logic [1:0]       lane_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             status_reg;
    logic             status_next;
    logic             bank_reg;
    logic             bank_next;
    logic [7:0]       word_reg;
    logic [7:0]       word_next;
    logic             last_reg;
    logic             last_next;

    logic [LANES-1:0] bri_we;
    logic [LANES-1:0] chan_we;
    logic [ROW_W-1:0] wr_row;
    logic             out_free;
    logic             is_chan_bank;
    logic [7:0]       emit_word;

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign bank      = bank_reg;
    assign word      = word_reg;
    assign last      = last_reg;

    assign wr_row       = cmd_reg.row[ROW_W-1:0];
    assign out_free     = !rsp_valid_reg || !rsp_stall;
    assign is_chan_bank = cmd_reg.kind != lcss_pkg::KIND_BRIGHT;

    // unwritten entries read as their reset value
    assign emit_word = is_chan_bank ?
        (chan_vld_rd_reg[lane_reg] ? chan_rd_reg[lane_reg] : 8'd0) :
        {2'b00, (bri_vld_rd_reg[lane_reg] ? bri_rd_reg[lane_reg] : lcss_pkg::BRI_RESET)};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        lane_next      = lane_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        bank_next      = bank_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        cmd_pop        = 1'b0;
        bri_we         = '0;
        chan_we        = '0;
        case (state_reg)
            lcss_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = lcss_pkg::ST_WRITE;
                end
            end
            lcss_pkg::ST_WRITE:
            begin
                if (cmd_reg.kind == lcss_pkg::KIND_ERR)
                begin
                    if (out_free)
                    begin
                        rsp_valid_next = 1'b1;
                        status_next    = 1'b1;
                        bank_next      = 1'b0;
                        word_next      = 8'd0;
                        last_next      = 1'b0;
                        state_next     = lcss_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        bri_we[l]  = cmd_reg.kind == lcss_pkg::KIND_BRIGHT;
                        chan_we[l] = (cmd_reg.kind == lcss_pkg::KIND_LED) ||
                                     ((cmd_reg.kind == lcss_pkg::KIND_CHAN) &&
                                      (cmd_reg.lane == 2'(l)));
                    end
                    if (cmd_reg.flush)
                    begin
                        row_next   = ROW_W'(LED_COUNT - 1);
                        state_next = lcss_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = lcss_pkg::ST_IDLE;
                    end
                end
            end
            lcss_pkg::ST_READ:
            begin
                lane_next  = 2'(LANES - 1);
                state_next = lcss_pkg::ST_EMIT;
            end
            lcss_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = 1'b0;
                    bank_next      = is_chan_bank;
                    word_next      = emit_word;
                    last_next      = (lane_reg == 2'd0) && (row_reg == '0);
                    if (lane_reg != 2'd0)
                        lane_next = lane_reg - 1'b1;
                    else if (row_reg == '0)
                        state_next = lcss_pkg::ST_IDLE;
                    else
                    begin
                        row_next   = row_reg - 1'b1;
                        state_next = lcss_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = lcss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcss_pkg::ST_IDLE;
            row_reg       <= '0;
            lane_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            bri_vld_reg   <= '0;
            chan_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            lane_reg      <= lane_next;
            rsp_valid_reg <= rsp_valid_next;
            for (int l = 0; l < LANES; l++)
            begin
                if (bri_we[l])
                    bri_vld_reg[l][wr_row] <= 1'b1;
                if (chan_we[l])
                    chan_vld_reg[l][wr_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        bank_reg   <= bank_next;
        word_reg   <= word_next;
        last_reg   <= last_next;
    end

    // one memory per lane, each row holds one LED
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (bri_we[l])
                bri_mem[l][wr_row] <= cmd_reg.val[l][5:0];
            if (chan_we[l])
                chan_mem[l][wr_row] <= cmd_reg.val[l];
            bri_rd_reg[l]      <= bri_mem[l][row_reg];
            chan_rd_reg[l]     <= chan_mem[l][row_reg];
            bri_vld_rd_reg[l]  <= bri_vld_reg[l][row_reg];
            chan_vld_rd_reg[l] <= chan_vld_reg[l][row_reg];
        end
    end

endmodule

// ===== sv/led_channel_store_serializer.sv =====
// Top level of the LED channel store serializer.
// Each request updates the brightness or channel store and, unless it is the body of a
// channel-write burst, emits the whole bank from the highest word down, the final word
// marked by last. A rejected request updates nothing and emits a single error word. A
// request is decoded, registered and queued; the back stage then pops it and applies it to
// the stores, and a flush then reads a row of the three lane memories and sends its three
// words out, LED by LED. Words leave through an output register and the command queue
// lets new requests enter while a flush runs.
module led_channel_store_serializer #(
    parameter int LED_COUNT = lcss_pkg::LED_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [2:0] mode,
    input  logic [4:0] led_index,
    input  logic [7:0] brightness_percent,
    input  logic [1:0] color_count,
    input  logic [7:0] red_value,
    input  logic [7:0] green_value,
    input  logic [7:0] blue_value,
    input  logic [6:0] channel_index,
    input  logic [7:0] channel_value,
    input  logic       burst_last,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic       status,
    output logic       bank,
    output logic [7:0] word,
    output logic       last
);

    logic           q_push;
    logic           q_ready;
    lcss_pkg::cmd_t q_in_cmd;
    logic           q_valid;
    lcss_pkg::cmd_t q_out_cmd;
    logic           q_pop;

    lcss_front #(
        .LED_COUNT(LED_COUNT)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid),
        .req_stall          (req_stall),
        .mode               (mode),
        .led_index          (led_index),
        .brightness_percent (brightness_percent),
        .color_count        (color_count),
        .red_value          (red_value),
        .green_value        (green_value),
        .blue_value         (blue_value),
        .channel_index      (channel_index),
        .channel_value      (channel_value),
        .burst_last         (burst_last),
        .push               (q_push),
        .push_cmd           (q_in_cmd),
        .push_ready         (q_ready)
    );

    lcss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_in_cmd),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop_cmd    (q_out_cmd),
        .pop        (q_pop)
    );

    lcss_back #(
        .LED_COUNT(LED_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_out_cmd),
        .cmd_pop   (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .bank      (bank),
        .word      (word),
        .last      (last)
    );

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> !bank && !last && (word == 8'd0))
        else $error("error word carries payload");

    a_bri_width: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !status && !bank |-> (word[7:6] == 2'b00))
        else $error("brightness word wider than six bits");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> q_push && !q_ready)
        else $error("request stalled while queue has room");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
